### rtl/group_product_aggregator_core_defines.svh
// ----------------------------------------------------------------------------
// Group product aggregator assertion macros
// Shared concurrent assertion shorthands, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef GROUP_PRODUCT_AGGREGATOR_CORE_DEFINES_SVH
`define GROUP_PRODUCT_AGGREGATOR_CORE_DEFINES_SVH

// same-cycle implication
`define GPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gpa_pkg.sv
// ----------------------------------------------------------------------------
// Group product aggregator package
// Sizes, codes, queue entry and state types shared by the core modules.
// ----------------------------------------------------------------------------
package gpa_pkg;

   localparam int MaxGroups  = 256;
   localparam int MaxColumns = 16;
   localparam int GroupBits  = $clog2(MaxGroups);
   localparam int ColBits    = $clog2(MaxColumns);
   localparam int ProdDepth  = MaxGroups * MaxColumns;
   localparam int AddrBits   = $clog2(ProdDepth);

   localparam logic [8:0] GroupsReset  = 9'd256;
   localparam logic [4:0] ColumnsReset = 5'd16;

   localparam logic [63:0] OneBits  = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_HALT    = 2'd2;

   localparam logic CSR_GROUPS  = 1'b0;
   localparam logic CSR_COLUMNS = 1'b1;

   typedef enum logic [1:0] {
      KIND_REPLY,
      KIND_ACC,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [1:0]             status;
      logic [GroupBits-1:0]   grp;
      logic [ColBits-1:0]     col;
      logic                   col_ok;
      logic                   mul_en;
      logic                   start;
      logic [63:0]            sample;
   } entry_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_ctl_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOK,
      BK_MUL,
      BK_RESP
   } bk_state_type;

   typedef enum logic [2:0] {
      FM_IDLE,
      FM_MUL,
      FM_NORM,
      FM_DENORM,
      FM_ROUND,
      FM_DONE
   } fm_state_type;

   function automatic logic is_nan(input logic [63:0] b);
      return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
   endfunction

endpackage

### rtl/group_product_aggregator_core.sv
// The back end runs one transaction at a time: pop, lookup and response, with the
// iterative double multiplier in between for accumulates that multiply; the multiplier
// skips its multiply steps when an operand is zero, infinite or NaN.
// Reset: synchronous; clears halt flag and queue, restores config defaults, then sweeps
// the product and count stores while requests are stalled.
// ----------------------------------------------------------------------------
// Group product aggregator core
// Group-by product engine with NaN skipping, per-group row counts and halt.
// ----------------------------------------------------------------------------
module group_product_aggregator_core import gpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic signed [8:0]  req_group_label,
   input  logic [3:0]         req_column_index,
   input  logic [63:0]        req_sample_value,
   input  logic               req_row_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [63:0]        rsp_product_value,
   output logic [31:0]        rsp_group_count,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [8:0]         csr_write_data
);

   back_ctl_type ctl;
   logic         q_valid;
   entry_type    q_entry;
   logic         mul_start, mul_done;
   logic [63:0]  mul_a, mul_b, mul_result;

   gpa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_group_label  (req_group_label),
      .req_column_index (req_column_index),
      .req_sample_value (req_sample_value),
      .req_row_start    (req_row_start),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .ctl              (ctl),
      .q_valid          (q_valid),
      .q_entry          (q_entry)
   );

   gpa_fmul u_fmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_result)
   );

   gpa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .ctl               (ctl),
      .mul_start         (mul_start),
      .mul_a             (mul_a),
      .mul_b             (mul_b),
      .mul_done          (mul_done),
      .mul_result        (mul_result),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_product_value (rsp_product_value),
      .rsp_group_count   (rsp_group_count)
   );

endmodule

### rtl/gpa_front.sv
// ----------------------------------------------------------------------------
// Group product aggregator front end
// Holds configuration and halt flag, classifies requests, queues them.
// ----------------------------------------------------------------------------
module gpa_front import gpa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic signed [8:0]   req_group_label,
   input  logic [3:0]          req_column_index,
   input  logic [63:0]         req_sample_value,
   input  logic                req_row_start,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [8:0]          csr_write_data,
   input  back_ctl_type        ctl,
   output logic                q_valid,
   output entry_type           q_entry
);

   logic [8:0]          groups_ff, groups_in;
   logic [4:0]          columns_ff, columns_in;
   logic                halted_ff, halted_in;
   entry_type           fifo_ff [2];
   logic                wptr_ff, rptr_ff;
   logic [1:0]          count_ff;
   logic                push;
   entry_type           item;
   logic [GroupBits-1:0] grp;
   logic                neg, out_range, col_ok;
   int                  glim, clim;

   assign req_stall = (count_ff == 2'd2) || ctl.clearing;
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = fifo_ff[rptr_ff];

   always_comb begin
      groups_in  = groups_ff;
      columns_in = columns_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GROUPS:  groups_in  = csr_write_data;
            CSR_COLUMNS: columns_in = csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      grp       = req_group_label[GroupBits-1:0];
      neg       = req_group_label[8];
      glim      = (int'(groups_ff) < MaxGroups) ? int'(groups_ff) : MaxGroups;
      clim      = (int'(columns_ff) < MaxColumns) ? int'(columns_ff) : MaxColumns;
      out_range = int'(grp) >= glim;
      col_ok    = int'(req_column_index) < clim;
      halted_in = halted_ff;
      item.kind   = KIND_REPLY;
      item.status = ST_OK;
      item.grp    = grp;
      item.col    = req_column_index;
      item.col_ok = col_ok;
      item.mul_en = col_ok && !is_nan(req_sample_value);
      item.start  = req_row_start;
      item.sample = req_sample_value;
      if (!req_action) begin
         if (halted_ff) begin
            item.status = ST_HALT;
         end else if (neg) begin
            item.status = ST_MISSING;
         end else if (out_range) begin
            item.status = ST_HALT;
            halted_in   = push;
         end else begin
            item.kind = KIND_ACC;
         end
      end else begin
         if (neg) begin
            item.status = ST_MISSING;
         end else if (out_range) begin
            item.status = ST_HALT;
         end else begin
            item.kind = KIND_READ;
         end
      end
      if (halted_ff) begin
         halted_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         groups_ff  <= GroupsReset;
         columns_ff <= ColumnsReset;
         halted_ff  <= 1'b0;
         wptr_ff    <= 1'b0;
         rptr_ff    <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         groups_ff  <= groups_in;
         columns_ff <= columns_in;
         halted_ff  <= halted_in;
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (ctl.pop) begin
            rptr_ff <= !rptr_ff;
         end
         case ({push, ctl.pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wptr_ff] <= item;
      end
   end

endmodule

### rtl/gpa_fmul.sv
// ----------------------------------------------------------------------------
// Group product aggregator double multiplier
// Iterative IEEE double multiply: four 32x32 partial products, stepwise
// normalize and denormalize, round to nearest even.
// ----------------------------------------------------------------------------
module gpa_fmul import gpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] result
);

   fm_state_type        state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic [52:0]         ma_ff, ma_in, mb_ff, mb_in;
   logic                sign_ff, sign_in;
   logic signed [12:0]  exp_ff, exp_in;
   logic [105:0]        acc_ff, acc_in;
   logic [63:0]         pp_ff, pp_in;
   logic [1:0]          ppsh_ff, ppsh_in;
   logic [6:0]          dsh_ff, dsh_in;
   logic [63:0]         res_ff, res_in;

   logic                a_zero, a_inf, a_nan, b_zero, b_inf, b_nan, special;
   logic [10:0]         ea, eb;
   logic [31:0]         opx, opy;
   logic [105:0]        addend;
   logic [6:0]          amt;
   logic                norm_hit, lost, up;
   logic signed [12:0]  e_norm, dneed, e_rnd;
   logic [53:0]         sum;
   logic [52:0]         rsig;

   assign a_zero  = (op_a[62:52] == 11'd0) && (op_a[51:0] == 52'd0);
   assign b_zero  = (op_b[62:52] == 11'd0) && (op_b[51:0] == 52'd0);
   assign a_inf   = (op_a[62:52] == 11'h7FF) && (op_a[51:0] == 52'd0);
   assign b_inf   = (op_b[62:52] == 11'h7FF) && (op_b[51:0] == 52'd0);
   assign a_nan   = is_nan(op_a);
   assign b_nan   = is_nan(op_b);
   assign special = a_zero || b_zero || a_inf || b_inf || a_nan || b_nan;
   assign ea      = (op_a[62:52] == 11'd0) ? 11'd1 : op_a[62:52];
   assign eb      = (op_b[62:52] == 11'd0) ? 11'd1 : op_b[62:52];
   assign amt     = 7'd64 >> step_ff;
   assign done    = (state_ff == FM_DONE);
   assign result  = res_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FM_IDLE:   if (start) begin
                       state_in = special ? FM_DONE : FM_MUL;
                    end
         FM_MUL:    if (step_ff == 3'd4) begin
                       state_in = FM_NORM;
                    end
         FM_NORM:   if (step_ff == 3'd6) begin
                       state_in = FM_DENORM;
                    end
         FM_DENORM: if (step_ff == 3'd6) begin
                       state_in = FM_ROUND;
                    end
         FM_ROUND:  state_in = FM_DONE;
         FM_DONE:   state_in = FM_IDLE;
         default:   state_in = FM_IDLE;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      sign_in  = sign_ff;
      exp_in   = exp_ff;
      acc_in   = acc_ff;
      pp_in    = pp_ff;
      ppsh_in  = ppsh_ff;
      dsh_in   = dsh_ff;
      res_in   = res_ff;
      opx      = step_ff[1] ? {11'd0, ma_ff[52:32]} : ma_ff[31:0];
      opy      = step_ff[0] ? {11'd0, mb_ff[52:32]} : mb_ff[31:0];
      case (ppsh_ff)
         2'd1:    addend = {42'd0, pp_ff} << 32;
         2'd2:    addend = {42'd0, pp_ff} << 64;
         default: addend = {42'd0, pp_ff};
      endcase
      norm_hit = (acc_ff >> (7'd106 - amt)) == 106'd0;
      e_norm   = norm_hit ? exp_ff - $signed({6'd0, amt}) : exp_ff;
      dneed    = 13'sd1 - e_norm;
      lost     = (acc_ff << (7'd106 - amt)) != 106'd0;
      up       = acc_ff[52] && ((acc_ff[51:0] != 52'd0) || acc_ff[53]);
      sum      = {1'b0, acc_ff[105:53]} + {53'd0, up};
      rsig     = sum[53] ? sum[53:1] : sum[52:0];
      e_rnd    = sum[53] ? exp_ff + 13'sd1 : exp_ff;
      case (state_ff)
         FM_IDLE: begin
            sign_in = op_a[63] ^ op_b[63];
            ma_in   = {op_a[62:52] != 11'd0, op_a[51:0]};
            mb_in   = {op_b[62:52] != 11'd0, op_b[51:0]};
            exp_in  = $signed({2'd0, ea}) + $signed({2'd0, eb}) - 13'sd1022;
            acc_in  = 106'd0;
            step_in = 3'd0;
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
               res_in = QnanBits;
            end else if (a_inf || b_inf) begin
               res_in = {op_a[63] ^ op_b[63], 11'h7FF, 52'd0};
            end else begin
               res_in = {op_a[63] ^ op_b[63], 63'd0};
            end
         end
         FM_MUL: begin
            pp_in = opx * opy;
            case (step_ff)
               3'd0:    ppsh_in = 2'd0;
               3'd3:    ppsh_in = 2'd2;
               default: ppsh_in = 2'd1;
            endcase
            if (step_ff != 3'd0) begin
               acc_in = acc_ff + addend;
            end
            step_in = (step_ff == 3'd4) ? 3'd0 : step_ff + 3'd1;
         end
         FM_NORM: begin
            if (norm_hit) begin
               acc_in = acc_ff << amt;
            end
            exp_in = e_norm;
            if (step_ff == 3'd6) begin
               if (e_norm < 13'sd1) begin
                  dsh_in = (dneed > 13'sd127) ? 7'd127 : dneed[6:0];
                  exp_in = 13'sd1;
               end else begin
                  dsh_in = 7'd0;
               end
            end
            step_in = (step_ff == 3'd6) ? 3'd0 : step_ff + 3'd1;
         end
         FM_DENORM: begin
            if (dsh_ff[3'd6 - step_ff]) begin
               acc_in = (acc_ff >> amt) | {105'd0, lost};
            end
            step_in = (step_ff == 3'd6) ? 3'd0 : step_ff + 3'd1;
         end
         FM_ROUND: begin
            if (e_rnd > 13'sd2046) begin
               res_in = {sign_ff, 11'h7FF, 52'd0};
            end else begin
               res_in = {sign_ff, rsig[52] ? e_rnd[10:0] : 11'd0, rsig[51:0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FM_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      sign_ff <= sign_in;
      exp_ff  <= exp_in;
      acc_ff  <= acc_in;
      pp_ff   <= pp_in;
      ppsh_ff <= ppsh_in;
      dsh_ff  <= dsh_in;
      res_ff  <= res_in;
   end

endmodule

### rtl/gpa_back.sv
// ----------------------------------------------------------------------------
// Group product aggregator back end
// Owns product and count stores, runs the clearing sweep, executes queued
// transactions and holds the response register.
// ----------------------------------------------------------------------------
`include "group_product_aggregator_core_defines.svh"

module gpa_back import gpa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  entry_type    q_entry,
   output back_ctl_type ctl,
   output logic         mul_start,
   output logic [63:0]  mul_a,
   output logic [63:0]  mul_b,
   input  logic         mul_done,
   input  logic [63:0]  mul_result,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [63:0]  rsp_product_value,
   output logic [31:0]  rsp_group_count
);

   logic [63:0]          prod_mem [ProdDepth];
   logic [31:0]          cnt_mem  [MaxGroups];

   bk_state_type         state_ff, state_in;
   logic [AddrBits-1:0]  clr_ff, clr_in;
   entry_type            cur_ff, cur_in;
   logic [63:0]          prod_rd_ff;
   logic [31:0]          cnt_rd_ff;
   logic [1:0]           res_status_ff, res_status_in;
   logic [63:0]          res_prod_ff, res_prod_in;
   logic [31:0]          res_cnt_ff, res_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [63:0]          rsp_prod_ff;
   logic [31:0]          rsp_cnt_ff;

   logic                 pw_en, cw_en, load;
   logic [AddrBits-1:0]  pw_addr, rd_addr, cur_addr;
   logic [63:0]          pw_data;
   logic [GroupBits-1:0] cw_addr;
   logic [31:0]          cw_data;

   assign rd_addr  = AddrBits'(int'(q_entry.grp) * MaxColumns + int'(q_entry.col));
   assign cur_addr = AddrBits'(int'(cur_ff.grp) * MaxColumns + int'(cur_ff.col));
   assign mul_a    = prod_rd_ff;
   assign mul_b    = cur_ff.sample;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_product_value = rsp_prod_ff;
   assign rsp_group_count   = rsp_cnt_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: if (clr_ff == AddrBits'(ProdDepth - 1)) begin
                      state_in = BK_IDLE;
                   end
         BK_IDLE:  if (q_valid) begin
                      state_in = BK_LOOK;
                   end
         BK_LOOK:  state_in = (cur_ff.kind == KIND_ACC && cur_ff.mul_en) ? BK_MUL : BK_RESP;
         BK_MUL:   if (mul_done) begin
                      state_in = BK_RESP;
                   end
         BK_RESP:  if (!rsp_valid_ff || !rsp_stall) begin
                      state_in = BK_IDLE;
                   end
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_prod_in   = res_prod_ff;
      res_cnt_in    = res_cnt_ff;
      ctl.clearing  = 1'b0;
      ctl.pop       = 1'b0;
      mul_start     = 1'b0;
      pw_en         = 1'b0;
      pw_addr       = cur_addr;
      pw_data       = mul_result;
      cw_en         = 1'b0;
      cw_addr       = cur_ff.grp;
      cw_data       = cnt_rd_ff + 32'd1;
      load          = 1'b0;
      case (state_ff)
         BK_CLEAR: begin
            ctl.clearing = 1'b1;
            pw_en        = 1'b1;
            pw_addr      = clr_ff;
            pw_data      = OneBits;
            cw_en        = int'(clr_ff) < MaxGroups;
            cw_addr      = GroupBits'(clr_ff);
            cw_data      = 32'd0;
            clr_in       = clr_ff + AddrBits'(1);
         end
         BK_IDLE: begin
            if (q_valid) begin
               ctl.pop = 1'b1;
               cur_in  = q_entry;
            end
         end
         BK_LOOK: begin
            res_status_in = cur_ff.status;
            res_prod_in   = 64'd0;
            res_cnt_in    = 32'd0;
            case (cur_ff.kind)
               KIND_ACC: begin
                  cw_en     = cur_ff.start && (cnt_rd_ff != 32'hFFFF_FFFF);
                  mul_start = cur_ff.mul_en;
               end
               KIND_READ: begin
                  res_prod_in = cur_ff.col_ok ? prod_rd_ff : 64'd0;
                  res_cnt_in  = cnt_rd_ff;
               end
               default: ;
            endcase
         end
         BK_MUL: begin
            pw_en = mul_done;
         end
         BK_RESP: begin
            load = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_prod_ff   <= res_prod_in;
      res_cnt_ff    <= res_cnt_in;
      if (load) begin
         rsp_status_ff <= res_status_ff;
         rsp_prod_ff   <= res_prod_ff;
         rsp_cnt_ff    <= res_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pw_en) begin
         prod_mem[pw_addr] <= pw_data;
      end
      prod_rd_ff <= prod_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cw_en) begin
         cnt_mem[cw_addr] <= cw_data;
      end
      cnt_rd_ff <= cnt_mem[q_entry.grp];
   end

   `GPA_ASSERT_NOW(a_done_in_wait, mul_done, state_ff == BK_MUL, "multiply finished outside wait")
   `GPA_ASSERT_NOW(a_load_free, load, !rsp_valid_ff || !rsp_stall, "response register overwritten")
   `GPA_ASSERT_NEXT(a_clear_end, state_ff == BK_CLEAR && clr_ff == AddrBits'(ProdDepth - 1), state_ff == BK_IDLE && clr_ff == '0, "clear sweep did not end")

endmodule
